// ===== rtl/core/packed_yuv_stream_to_rgb_top_macros.svh =====
// Assertion helpers shared by the core RTL.
`ifndef PACKED_YUV_STREAM_TO_RGB_TOP_MACROS_SVH
`define PACKED_YUV_STREAM_TO_RGB_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PYR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define PYR_ASSERT_IMPLIES(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Check that a trigger implies a condition in the following cycle.
`define PYR_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/pyr_pkg.sv =====
package pyr_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } pyr_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pyr_out_t;

  typedef logic signed [6:0] pyr_u_term_t;
  typedef logic signed [7:0] pyr_v_term_t;

  typedef struct packed {
    logic [7:0]  y0;
    logic [7:0]  y1;
    logic        two;
    pyr_u_term_t u_term;
    pyr_v_term_t v_term;
  } pyr_cmd_t;

  localparam logic FMT_422 = 1'b0;
  localparam logic FMT_411 = 1'b1;

  localparam logic [2:0] GLEN_422 = 3'd4;
  localparam logic [2:0] GLEN_411 = 3'd6;

  localparam logic [2:0] POS_CHROMA_U = 3'd0;
  localparam logic [2:0] POS_LUMA0    = 3'd1;
  localparam logic [2:0] POS_422_V    = 3'd2;
  localparam logic [2:0] POS_422_Y1   = 3'd3;
  localparam logic [2:0] POS_411_Y1   = 3'd2;
  localparam logic [2:0] POS_411_V    = 3'd3;

  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

  // floor(m * 177 / 500) == (m * U_MUL) >> U_SHIFT for m in 0..128
  localparam logic [14:0] U_MUL   = 15'd23200;
  localparam int          U_SHIFT = 16;
  // floor(m * 707 / 1000) == (m * V_MUL) >> V_SHIFT for m in 0..128
  localparam logic [19:0] V_MUL   = 20'd741344;
  localparam int          V_SHIFT = 20;

  function automatic logic [7:0] chroma_mag(input logic [7:0] b);
    return b[7] ? {1'b0, b[6:0]} : (CHROMA_OFFSET - b);
  endfunction

  function automatic pyr_u_term_t u_term_of(input logic [7:0] b);
    logic [22:0] prod;
    logic [6:0]  q;
    prod = chroma_mag(b) * U_MUL;
    q    = prod[U_SHIFT+6:U_SHIFT];
    return b[7] ? pyr_u_term_t'(q) : pyr_u_term_t'(~q + 7'd1);
  endfunction

  function automatic pyr_v_term_t v_term_of(input logic [7:0] b);
    logic [27:0] prod;
    logic [7:0]  q;
    prod = chroma_mag(b) * V_MUL;
    q    = prod[V_SHIFT+7:V_SHIFT];
    return b[7] ? pyr_v_term_t'(q) : pyr_v_term_t'(~q + 8'd1);
  endfunction

  function automatic logic [7:0] sat8(input logic signed [10:0] x);
    logic [7:0] r;
    if (x[10]) begin
      r = 8'd0;
    end else if (x[9:8] != 2'b00) begin
      r = 8'd255;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pyr_front.sv =====
module pyr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             format_mode,
  input  logic             byte_valid,
  input  pyr_pkg::pyr_in_t byte_data,
  output logic             byte_stall,
  input  logic             q_full,
  output logic             push,
  output pyr_pkg::pyr_cmd_t cmd
);
  import pyr_pkg::*;

  logic [2:0]  pos;
  logic [2:0]  pos_next;
  pyr_u_term_t u_term;
  pyr_v_term_t v_term;
  logic [7:0]  luma0;
  logic [7:0]  luma1;

  logic        accept;
  logic [2:0]  glen;
  logic [2:0]  p;
  logic [2:0]  p_inc;
  logic [7:0]  b;
  pyr_u_term_t u_new;
  pyr_v_term_t v_new;
  logic        upd_u;
  logic        upd_v;
  logic        wr_l0;
  logic        wr_l1;

  assign byte_stall = q_full;
  assign accept     = byte_valid & ~q_full;
  assign b          = byte_data.data_byte;
  assign u_new      = u_term_of(b);
  assign v_new      = v_term_of(b);

  always_comb begin
    glen  = (format_mode == FMT_411) ? GLEN_411 : GLEN_422;
    p     = (byte_data.frame_start || pos >= glen) ? POS_CHROMA_U : pos;
    p_inc = p + 3'd1;
    pos_next = (p_inc == glen) ? POS_CHROMA_U : p_inc;

    upd_u = 1'b0;
    upd_v = 1'b0;
    wr_l0 = 1'b0;
    wr_l1 = 1'b0;
    push  = 1'b0;
    cmd.y0     = b;
    cmd.y1     = luma1;
    cmd.two    = 1'b0;
    cmd.u_term = u_term;
    cmd.v_term = v_term;

    priority if (p == POS_CHROMA_U) begin
      upd_u = accept;
    end else if (p == POS_LUMA0) begin
      wr_l0 = accept;
    end else if (format_mode == FMT_422) begin
      if (p == POS_422_V) begin
        upd_v      = accept;
        cmd.y0     = luma0;
        cmd.v_term = v_new;
      end
      push = accept;
    end else if (p == POS_411_Y1) begin
      wr_l1 = accept;
    end else if (p == POS_411_V) begin
      upd_v      = accept;
      cmd.y0     = luma0;
      cmd.two    = 1'b1;
      cmd.v_term = v_new;
      push       = accept;
    end else begin
      push = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= POS_CHROMA_U;
      u_term <= '0;
      v_term <= '0;
    end else begin
      if (accept) begin
        pos <= pos_next;
      end
      if (upd_u) begin
        u_term <= u_new;
      end
      if (upd_v) begin
        v_term <= v_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_l0) begin
      luma0 <= b;
    end
    if (wr_l1) begin
      luma1 <= b;
    end
  end

endmodule

// ===== rtl/core/pyr_queue.sv =====
`include "packed_yuv_stream_to_rgb_top_macros.svh"

module pyr_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pyr_pkg::pyr_cmd_t push_cmd,
  output logic              full,
  output logic              not_empty,
  output pyr_pkg::pyr_cmd_t head,
  input  logic              pop
);
  import pyr_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pyr_cmd_t           entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `PYR_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "queue count past depth")
  `PYR_ASSERT_IMPLIES(a_pop_nonempty, pop, count != '0, "pop from empty queue")
  `PYR_ASSERT_IMPLIES(a_push_room, push, count != CNT_W'(DEPTH), "push into full queue")

endmodule

// ===== rtl/core/pyr_back.sv =====
`include "packed_yuv_stream_to_rgb_top_macros.svh"

module pyr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              not_empty,
  input  pyr_pkg::pyr_cmd_t head,
  output logic              pop,
  output logic              pix_valid,
  output pyr_pkg::pyr_out_t pix_data,
  input  logic              pix_stall
);
  import pyr_pkg::*;

  logic              second;
  logic              load;
  logic              take;
  logic [7:0]        y;
  logic signed [10:0] y_ext;
  logic signed [10:0] u_ext;
  logic signed [10:0] v_ext;
  pyr_out_t          pix_next;

  assign load = ~pix_valid | ~pix_stall;
  assign take = load & not_empty;
  assign pop  = take & (~head.two | second);

  always_comb begin
    y     = second ? head.y1 : head.y0;
    y_ext = signed'({3'b000, y});
    u_ext = 11'(head.u_term);
    v_ext = 11'(head.v_term);
    pix_next.red   = sat8(y_ext + (v_ext <<< 1));
    pix_next.green = sat8(y_ext - u_ext - v_ext);
    pix_next.blue  = sat8(y_ext + (u_ext <<< 2) + u_ext);
    pix_next.last  = ~head.two | second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        pix_valid <= not_empty;
      end
      if (take) begin
        second <= head.two & ~second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_data <= pix_next;
    end
  end

  `PYR_ASSERT_IMPLIES(a_second_pending, second, not_empty && head.two,
                      "second pixel pending without a paired entry")
  `PYR_ASSERT_NEXT(a_pair_follows, pix_valid && !pix_data.last, pix_valid,
                   "first pixel of a pair not followed by its partner")

endmodule

// ===== rtl/core/packed_yuv_stream_to_rgb_top.sv =====
// Channel   Direction  Handshake             Payload
// byte      in         byte_valid/byte_stall  pyr_in_t  {data_byte, frame_start}
// pix       out        pix_valid/pix_stall    pyr_out_t {red, green, blue, last}
// cfg       in         cfg_we                 cfg_wdata = format_mode
//
// One byte is taken every cycle while the command queue has room.
// A pixel is registered in the command queue, then in the output register (YUV411 y2/y3
// queue behind the v byte's pair); a YUV411 v byte yields two output pixels.
// byte_stall rises only when the QUEUE_DEPTH-entry command queue is full.
// pix_stall holds the output register and lets the queue fill behind it.
// rst (synchronous) clears group position, chroma terms, format and valids.
module packed_yuv_stream_to_rgb_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              byte_valid,
  input  pyr_pkg::pyr_in_t  byte_data,
  output logic              byte_stall,
  output logic              pix_valid,
  output pyr_pkg::pyr_out_t pix_data,
  input  logic              pix_stall
);
  import pyr_pkg::*;

  logic     format_mode;
  logic     q_full;
  logic     q_not_empty;
  logic     push;
  logic     pop;
  pyr_cmd_t push_cmd;
  pyr_cmd_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= FMT_422;
    end else if (cfg_we) begin
      format_mode <= cfg_wdata;
    end
  end

  pyr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .format_mode (format_mode),
    .byte_valid  (byte_valid),
    .byte_data   (byte_data),
    .byte_stall  (byte_stall),
    .q_full      (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  pyr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head),
    .pop       (pop)
  );

  pyr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .head      (head),
    .pop       (pop),
    .pix_valid (pix_valid),
    .pix_data  (pix_data),
    .pix_stall (pix_stall)
  );

endmodule

// ===== test/yuv_rgb_checker.sv =====
`timescale 1ns / 100ps

module yuv_rgb_checker
  import pyr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     byte_valid,
  input  pyr_in_t  byte_data,
  input  logic     byte_stall,
  input  logic     pix_valid,
  input  pyr_out_t pix_data,
  input  logic     pix_stall,
  output int       mismatches,
  output int       due_count,
  output int       pixels_checked
);

  localparam int U_NUM = 177;
  localparam int U_DEN = 500;
  localparam int V_NUM = 707;
  localparam int V_DEN = 1000;
  localparam int MID   = 128;

  logic        fmt;
  logic [2:0]  grp_pos;
  pyr_u_term_t u_term;
  pyr_v_term_t v_term;
  logic [7:0]  luma_hold [2];
  pyr_out_t    pixels_due [$];

  function automatic logic [7:0] clip8(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return 8'(x);
  endfunction

  function automatic pyr_out_t rgb_of(input logic [7:0] y, input logic is_last);
    pyr_out_t px;
    int       yy;
    yy = int'(y);
    px.red   = clip8(yy + 2 * int'(v_term));
    px.green = clip8(yy - int'(u_term) - int'(v_term));
    px.blue  = clip8(yy + 5 * int'(u_term));
    px.last  = is_last;
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("pixel %0d %s got %0d expected %0d",
                                pixels_checked, name, got, want));
    end
  endtask

  task automatic take_byte(input pyr_in_t b);
    logic [2:0] glen;
    logic [2:0] p;
    int         c;
    glen = (fmt == FMT_411) ? GLEN_411 : GLEN_422;
    p = grp_pos;
    if (b.frame_start || p >= glen) p = POS_CHROMA_U;
    c = int'(b.data_byte) - MID;
    if (p == POS_CHROMA_U) begin
      u_term = pyr_u_term_t'((c * U_NUM) / U_DEN);
    end else if (fmt == FMT_422) begin
      case (p)
        POS_LUMA0: begin
          luma_hold[0] = b.data_byte;
        end
        POS_422_V: begin
          v_term = pyr_v_term_t'((c * V_NUM) / V_DEN);
          pixels_due.push_back(rgb_of(luma_hold[0], 1'b1));
        end
        default: begin
          pixels_due.push_back(rgb_of(b.data_byte, 1'b1));
        end
      endcase
    end else begin
      case (p)
        POS_LUMA0: begin
          luma_hold[0] = b.data_byte;
        end
        POS_411_Y1: begin
          luma_hold[1] = b.data_byte;
        end
        POS_411_V: begin
          v_term = pyr_v_term_t'((c * V_NUM) / V_DEN);
          pixels_due.push_back(rgb_of(luma_hold[0], 1'b0));
          pixels_due.push_back(rgb_of(luma_hold[1], 1'b1));
        end
        default: begin
          pixels_due.push_back(rgb_of(b.data_byte, 1'b1));
        end
      endcase
    end
    p = p + 3'd1;
    if (p >= glen) p = POS_CHROMA_U;
    grp_pos = p;
  endtask

  always @(posedge clk) begin : watch
    pyr_out_t want;
    if (rst) begin
      fmt = FMT_422;
      grp_pos = POS_CHROMA_U;
      u_term = '0;
      v_term = '0;
      pixels_due.delete();
    end else begin
      if (cfg_we) fmt = cfg_wdata;
      if (byte_valid && !byte_stall) take_byte(byte_data);
      if (pix_valid && !pix_stall) begin
        if (pixels_due.size() == 0) begin
          report_mismatch($sformatf("pixel %0d with none expected (r=%0d g=%0d b=%0d last=%0d)",
                                    pixels_checked, pix_data.red, pix_data.green,
                                    pix_data.blue, pix_data.last));
        end else begin
          want = pixels_due.pop_front();
          check_field("red", int'(pix_data.red), int'(want.red));
          check_field("green", int'(pix_data.green), int'(want.green));
          check_field("blue", int'(pix_data.blue), int'(want.blue));
          check_field("last", int'(pix_data.last), int'(want.last));
        end
        pixels_checked++;
      end
    end
    due_count = pixels_due.size();
  end

endmodule

// ===== test/tb_packed_yuv_stream_to_rgb_top.sv =====
`timescale 1ns / 100ps

module tb_packed_yuv_stream_to_rgb_top;
  import pyr_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int SETTLE      = 8;
  localparam int TOTAL_BYTES = 530;

  logic     clk;
  logic     rst;
  logic     cfg_we;
  logic     cfg_wdata;
  logic     byte_valid;
  pyr_in_t  byte_data;
  logic     byte_stall;
  logic     pix_valid;
  pyr_out_t pix_data;
  logic     pix_stall;

  int mismatches;
  int due_count;
  int pixels_checked;
  int cycles;
  int bytes_sent;
  int fmt_writes;
  int byte_pace;
  int pix_pace;
  logic fmt_now;

  packed_yuv_stream_to_rgb_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_stall (byte_stall),
    .pix_valid  (pix_valid),
    .pix_data   (pix_data),
    .pix_stall  (pix_stall)
  );

  yuv_rgb_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .byte_valid     (byte_valid),
    .byte_data      (byte_data),
    .byte_stall     (byte_stall),
    .pix_valid      (pix_valid),
    .pix_data       (pix_data),
    .pix_stall      (pix_stall),
    .mismatches     (mismatches),
    .due_count      (due_count),
    .pixels_checked (pixels_checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int wait_draw(input int pace);
    if (pace == 0) return 0;
    if (pace == 1) return $urandom_range(0, 13);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic fs);
    pyr_in_t beat;
    int      w;
    beat.data_byte   = b;
    beat.frame_start = fs;
    w = wait_draw(byte_pace);
    @(negedge clk);
    if (w > 0) begin
      byte_valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= beat;
    do @(posedge clk); while (!(byte_valid && !byte_stall));
    bytes_sent++;
  endtask

  // drain, then give the pipeline time to retire bytes that make no pixel
  task automatic settle();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_format(input logic f);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(negedge clk);
    cfg_we <= 1'b0;
    fmt_now = f;
    fmt_writes++;
  endtask

  task automatic send_group(input int len, input logic fs_first);
    for (int i = 0; i < len; i++) begin
      send_beat(pick_byte(), (i == 0) ? fs_first : 1'b0);
    end
  endtask

  // receiver: hold stall for a drawn number of cycles, then take one beat
  initial begin : pix_side
    int w;
    wait (rst === 1'b0);
    forever begin
      w = wait_draw(pix_pace);
      @(negedge clk);
      if (w > 0) begin
        pix_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      pix_stall <= 1'b0;
      do @(posedge clk); while (!(pix_valid && !pix_stall));
    end
  end

  initial begin : stimulus
    int   groups;
    int   glen;
    int   len;
    bytes_sent = 0;
    fmt_writes = 0;
    byte_pace  = 0;
    pix_pace   = 0;
    fmt_now    = FMT_422;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = FMT_422;
    byte_valid = 1'b0;
    byte_data  = '0;
    pix_stall  = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // full YUV411 group first so both held luma bytes get written
    set_format(FMT_411);
    send_beat(8'd0, 1'b1);
    send_beat(8'd255, 1'b0);
    send_beat(8'd0, 1'b0);
    send_beat(8'd255, 1'b0);
    send_beat(8'd128, 1'b0);
    send_beat(8'd1, 1'b0);
    byte_pace = 1;
    pix_pace  = 1;
    send_beat(8'd255, 1'b1);
    send_beat(8'd0, 1'b0);
    send_beat(8'd255, 1'b0);
    send_beat(8'd0, 1'b0);
    // frame start drops the rest of the group
    send_beat(8'd128, 1'b1);
    send_beat(8'd50, 1'b0);
    send_beat(8'd60, 1'b0);
    send_beat(8'd128, 1'b0);
    send_beat(8'd200, 1'b0);
    // position now beyond a YUV422 group
    set_format(FMT_422);
    send_beat(8'd200, 1'b0);
    send_beat(8'd77, 1'b0);
    send_beat(8'd60, 1'b0);
    send_beat(8'd10, 1'b0);
    send_beat(8'd1, 1'b1);
    send_beat(8'd254, 1'b0);
    // switch packing in mid-group
    set_format(FMT_411);
    send_beat(8'd99, 1'b0);
    send_beat(8'd127, 1'b0);

    while (bytes_sent < TOTAL_BYTES) begin
      set_format(1'($urandom_range(0, 1)));
      byte_pace = $urandom_range(0, 2);
      pix_pace  = $urandom_range(0, 2);
      groups = $urandom_range(2, 12);
      glen = (fmt_now == FMT_411) ? int'(GLEN_411) : int'(GLEN_422);
      for (int g = 0; g < groups; g++) begin
        if ($urandom_range(0, 4) == 0) begin
          len = $urandom_range(1, 5);
          for (int i = 0; i < len; i++) begin
            send_beat(pick_byte(), $urandom_range(0, 3) == 0);
          end
        end else begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, glen) : glen;
          send_group(len, $urandom_range(0, 3) != 0);
        end
      end
    end

    @(negedge clk);
    byte_valid <= 1'b0;
    while (due_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("run: %0d bytes sent over %0d format writes, %0d pixels compared",
             bytes_sent, fmt_writes, pixels_checked);
    if (due_count != 0) $display("pixels still expected: %0d", due_count);
    if (mismatches == 0 && due_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pyr_pkg.sv
rtl/core/pyr_front.sv
rtl/core/pyr_queue.sv
rtl/core/pyr_back.sv
rtl/core/packed_yuv_stream_to_rgb_top.sv
test/yuv_rgb_checker.sv
test/tb_packed_yuv_stream_to_rgb_top.sv
